/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is held low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* sv/htsc_pkg.sv */
`default_nettype none

package htsc_pkg;

    // Heading in hundredths of a degree, 0..35999
    typedef logic [15:0] t_angle;
    // Wide signed working value for sums of a heading and a turn request
    typedef logic signed [17:0] t_wide;

    localparam t_wide  FULL_TURN  = 18'sd36000;
    localparam t_wide  DOUBLE_TURN = 18'sd72000;
    localparam t_angle HALF_TURN  = 16'd18000;
    localparam t_angle SLOW_ZONE  = 16'd3000;
    localparam t_angle DONE_BAND  = 16'd150;
    localparam t_angle DONE_UPPER = 16'd35850;   // full turn minus done band
    localparam logic [15:0] RAMP_TICKS = 16'd20;
    localparam logic [15:0] TICK_MAX   = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd250;

    // Speed levels, thousandths
    localparam logic [9:0] SPEED_PROP_BASE = 10'd600;
    localparam logic [9:0] SPEED_RAMP_BASE = 10'd450;
    localparam logic [9:0] SPEED_FULL      = 10'd1000;
    localparam logic [5:0] RAMP_SLOPE      = 6'd55;

    // floor(x / 30) = (x * RECIP_30) >> RECIP_SHIFT for x below 12012
    localparam logic [14:0] RECIP_30    = 15'd17477;
    localparam int          RECIP_SHIFT = 19;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_TURN_ANGLE    = 2'd0;
    localparam logic [1:0] REG_ABSOLUTE_MODE = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    // Request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // True modulo 36000 for values in -72000..107999
    function automatic t_angle wrap_angle(input t_wide a);
        t_wide r;
        begin
            if (a >= DOUBLE_TURN) begin
                r = a - DOUBLE_TURN;
            end else if (a >= FULL_TURN) begin
                r = a - FULL_TURN;
            end else if (a < -FULL_TURN) begin
                r = a + DOUBLE_TURN;
            end else if (a < 18'sd0) begin
                r = a + FULL_TURN;
            end else begin
                r = a;
            end
            return r[15:0];
        end
    endfunction

    // Absolute difference of two headings
    function automatic t_angle angle_dist(input t_angle a, input t_angle b);
        begin
            return (a >= b) ? (a - b) : (b - a);
        end
    endfunction

endpackage

`default_nettype wire

/* sv/heading_turn_speed_controller.sv */
// Each input word is captured in the input register; its result is written to the result register.
// Throughput: one word per cycle while the result stream is taken, set by the single compute stage
//   between the input register and the result register; each result updates the state.
// Reset (synchronous, active low) clears the turn state and the registers:
//   turn_angle 0, relative mode, timeout 250 ticks, no turn active.
`default_nettype none

`include "assert_macros.svh"

module heading_turn_speed_controller
    import htsc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [16:0] i_cfg_data,
    // input stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,    // [15:0] yaw
    input  wire  [0:0]  i_s_tuser,    // [0] req_type
    // result stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata,    // [10:0] drive_speed, [11] timed_out, [15:12] zero
    output logic        o_m_tlast     // done_res
);

    // configuration registers
    logic signed [16:0] r_turn_angle;
    logic               r_absolute;
    logic [15:0]        r_timeout;

    // input register
    logic               r_in_valid;
    logic               r_in_req;
    logic signed [15:0] r_in_yaw;

    // turn state
    t_angle             r_target, n_target;
    t_angle             r_current, n_current;
    t_angle             r_previous, n_previous;
    logic               r_cw, n_cw;
    logic [15:0]        r_tick, n_tick;
    logic               r_active, n_active;

    // result register
    logic               r_out_valid;
    logic signed [10:0] r_out_speed, n_out_speed;
    logic               r_out_done, n_out_done;
    logic               r_out_tmo, n_out_tmo;

    logic               w_adv;
    logic               w_s_accept;

    assign o_cfg_ready = 1'b1;
    assign w_adv       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || !r_out_valid || i_m_tready;
    assign w_s_accept  = i_s_tvalid && o_s_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_angle <= '0;
            r_absolute   <= 1'b0;
            r_timeout    <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TURN_ANGLE:    r_turn_angle <= i_cfg_data;
                REG_ABSOLUTE_MODE: r_absolute   <= i_cfg_data[0];
                REG_TIMEOUT_TICKS: r_timeout    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_in_req <= i_s_tuser[0];
            r_in_yaw <= i_s_tdata;
        end
    end

    // compute stage
    t_angle             w_yaw_wrap;
    t_wide              w_tgt_raw;
    t_wide              w_c18, w_t18;
    t_angle             w_tgt;
    logic               w_cw;
    logic [15:0]        w_tick_inc;
    t_angle             w_err_raw, w_err;
    logic [13:0]        w_prop_num;
    logic [28:0]        w_prop_prod;
    logic [9:0]         w_prop_q;
    logic [10:0]        w_ramp_num;
    logic [9:0]         w_mag;
    t_angle             w_e1;
    logic               w_finished;
    logic               w_timeout;

    always_comb begin
        // wrap the measured yaw and form the start target
        w_yaw_wrap = wrap_angle({{2{r_in_yaw[15]}}, r_in_yaw});
        if (r_absolute) begin
            w_tgt_raw = {r_turn_angle[16], r_turn_angle};
        end else begin
            w_tgt_raw = $signed({2'b00, w_yaw_wrap}) + $signed({r_turn_angle[16], r_turn_angle});
        end
        w_tgt = wrap_angle(w_tgt_raw);

        // shorter turn direction
        w_c18 = $signed({2'b00, w_yaw_wrap});
        w_t18 = $signed({2'b00, w_tgt});
        if (w_t18 > w_c18) begin
            w_cw = (w_t18 - w_c18) < (w_c18 + FULL_TURN - w_t18);
        end else begin
            w_cw = (w_c18 - w_t18) > (w_t18 + FULL_TURN - w_c18);
        end

        // saturating tick count
        w_tick_inc = (r_tick == TICK_MAX) ? r_tick : r_tick + 16'd1;

        // heading error before this tick, folded to the short way round
        w_err_raw = angle_dist(r_current, r_target);
        w_err = (w_err_raw > HALF_TURN) ? (t_angle'(FULL_TURN[15:0]) - w_err_raw) : w_err_raw;

        // proportional speed: 600 + round(err * 4 / 30)
        w_prop_num  = {w_err[11:0], 2'b00} + 14'd15;
        w_prop_prod = w_prop_num * RECIP_30;
        w_prop_q    = w_prop_prod[28:RECIP_SHIFT];

        // ramp speed: 450 + round(55 * tick / 2)
        w_ramp_num = RAMP_SLOPE * w_tick_inc[4:0] + 11'd1;

        if (w_err < SLOW_ZONE) begin
            w_mag = SPEED_PROP_BASE + w_prop_q;
        end else if (w_tick_inc < RAMP_TICKS) begin
            w_mag = SPEED_RAMP_BASE + w_ramp_num[10:1];
        end else begin
            w_mag = SPEED_FULL;
        end

        // completion against the newly measured heading
        w_e1       = angle_dist(r_target, w_yaw_wrap);
        w_finished = (r_current != w_yaw_wrap) && ((w_e1 < DONE_BAND) || (w_e1 > DONE_UPPER));
        w_timeout  = w_tick_inc >= r_timeout;

        n_target    = r_target;
        n_current   = r_current;
        n_previous  = r_previous;
        n_cw        = r_cw;
        n_tick      = r_tick;
        n_active    = r_active;
        n_out_speed = '0;
        n_out_done  = 1'b0;
        n_out_tmo   = 1'b0;

        if (r_in_req == REQ_START) begin
            n_target   = w_tgt;
            n_current  = w_yaw_wrap;
            n_previous = w_yaw_wrap;
            n_cw       = w_cw;
            n_tick     = '0;
            n_active   = 1'b1;
        end else if (r_active) begin
            n_tick      = w_tick_inc;
            n_previous  = r_current;
            n_current   = w_yaw_wrap;
            n_out_speed = r_cw ? $signed({1'b0, w_mag}) : -$signed({1'b0, w_mag});
            if (w_timeout || w_finished) begin
                n_out_done = 1'b1;
                n_out_tmo  = w_timeout;
                n_active   = 1'b0;
            end
        end
    end

    // turn state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= '0;
            r_current  <= '0;
            r_previous <= '0;
            r_cw       <= 1'b0;
            r_tick     <= '0;
            r_active   <= 1'b0;
        end else if (w_adv) begin
            r_target   <= n_target;
            r_current  <= n_current;
            r_previous <= n_previous;
            r_cw       <= n_cw;
            r_tick     <= n_tick;
            r_active   <= n_active;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_speed <= n_out_speed;
            r_out_done  <= n_out_done;
            r_out_tmo   <= n_out_tmo;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_tmo, r_out_speed};
    assign o_m_tlast  = r_out_done;

    // checks
    `ASSERT_CLK(a_heading_range, i_clk, i_rst_n, (r_target < FULL_TURN[15:0]) && (r_current < FULL_TURN[15:0]))
    `ASSERT_CLK(a_end_of_turn_flagged, i_clk, i_rst_n, $fell(r_active) |-> (o_m_tvalid && o_m_tlast))
    `ASSERT_CLK(a_in_reg_holds, i_clk, i_rst_n, (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_yaw)))
    `ASSERT_CLK(a_timeout_is_done, i_clk, i_rst_n, (o_m_tvalid && o_m_tdata[11]) |-> o_m_tlast)

endmodule

`default_nettype wire
